// ----- rtl/mlfq_pkg.sv -----
// Shared types, codes and defaults for the multilevel feedback queue scheduler.
package mlfq_pkg;

    localparam int DEF_MAX_LEVELS = 8;
    localparam int DEF_MAX_PROCS  = 16;

    localparam int PID_W    = 4;
    localparam int KIND_W   = 3;
    localparam int OUTLVL_W = 3;
    localparam int LVLS_W   = 4;   // level index width carried between modules (up to 16)
    localparam int PERIOD_W = 10;
    localparam int LCNT_W   = 4;
    localparam int IN_W     = 8;
    localparam int OUT_W    = 16;
    localparam int CFG_W    = 10;

    localparam logic [LCNT_W-1:0]   LEVEL_COUNT_RST  = 4'd3;
    localparam logic [PERIOD_W-1:0] BOOST_PERIOD_RST = 10'd8;

    typedef enum logic [KIND_W-1:0] {
        KIND_STAYED   = 3'd0,
        KIND_DEMOTED  = 3'd1,
        KIND_EXITED   = 3'd2,
        KIND_BOOSTED  = 3'd3,
        KIND_IDLE     = 3'd4,
        KIND_ADMITTED = 3'd5,
        KIND_REJECTED = 3'd6
    } kind_t;

    typedef enum logic {
        CMD_ADMIT = 1'b0,
        CMD_RUN   = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        OUT_YIELD  = 2'd0,
        OUT_DEMOTE = 2'd1,
        OUT_EXIT   = 2'd2,
        OUT_EXIT_X = 2'd3
    } outcome_t;

    typedef enum logic {
        CFG_LEVEL_COUNT  = 1'b0,
        CFG_BOOST_PERIOD = 1'b1
    } cfg_index_t;

    // where a pushed or reported process id comes from
    typedef enum logic [1:0] {
        PID_FROM_IN   = 2'd0,
        PID_FROM_READ = 2'd1,
        PID_ZERO      = 2'd2
    } pid_src_t;

    // controller to datapath
    typedef struct packed {
        logic              ld_in;
        logic              pop_en;
        logic [LVLS_W-1:0] pop_lvl;
        logic              push_en;
        logic [LVLS_W-1:0] push_lvl;
        pid_src_t          pid_src;
        logic              emit;
        kind_t             kind;
        logic [LVLS_W-1:0] emit_lvl;
        logic              last;
        logic              cnt_clr;
        logic              cnt_inc;
        logic              ld_cur;
    } mlfq_cmd_t;

    // datapath to controller
    typedef struct packed {
        command_t          command;
        outcome_t          outcome;
        logic              top_full;
        logic              boost_due;
        logic              boost_hit;
        logic [LVLS_W-1:0] boost_lvl;
        logic              any_hit;
        logic [LVLS_W-1:0] head_lvl;
        logic [LVLS_W-1:0] cur_lvl;
        logic [LVLS_W-1:0] tgt_lvl;
        logic              out_busy;
    } mlfq_sts_t;

endpackage

// ----- rtl/mlfq_scheduler_with_boost.sv -----
// Top level of the multilevel feedback queue scheduler with priority boost.
// An admit item is accepted, then gives its result. A run item is accepted, then the
// latched item is decoded, the head is read from the level store and the result given;
// a run item that finds every level empty gives the idle result in place of the head read.
// When a boost is due, each lifted process adds a move that reads the level store and
// then writes the read value to the top level, and a last search step ends the boost.
// Results wait in one output register; the sequencer holds while it is full.
// Configuration writes are taken every cycle.
module mlfq_scheduler_with_boost #(
    parameter int MAX_LEVELS = mlfq_pkg::DEF_MAX_LEVELS,
    parameter int MAX_PROCS  = mlfq_pkg::DEF_MAX_PROCS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_tvalid,
    output logic                       in_tready,
    input  logic [mlfq_pkg::IN_W-1:0]  in_tdata,   // command, process_id, outcome
    output logic                       out_tvalid,
    input  logic                       out_tready,
    output logic [mlfq_pkg::OUT_W-1:0] out_tdata,  // kind, process_id_res, level
    output logic                       out_tlast,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [mlfq_pkg::CFG_W-1:0] cfg_data
);
    import mlfq_pkg::*;

    mlfq_cmd_t cmd;
    mlfq_sts_t sts;

    assign cfg_ready = 1'b1;

    mlfq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tvalid (in_tvalid),
        .in_tready (in_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    mlfq_dpath #(
        .MAX_LEVELS (MAX_LEVELS),
        .MAX_PROCS  (MAX_PROCS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_tdata   (in_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_tvalid (out_tvalid),
        .out_tready (out_tready),
        .out_tdata  (out_tdata),
        .out_tlast  (out_tlast),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

// ----- rtl/mlfq_ctrl.sv -----
// Sequencer for admit, boost and slice steps.
module mlfq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_tvalid,
    output logic              in_tready,
    input  mlfq_pkg::mlfq_sts_t sts,
    output mlfq_pkg::mlfq_cmd_t cmd
);
    import mlfq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADMIT,
        S_BFIND,
        S_BPUSH,
        S_PICK,
        S_SLICE
    } state_t;

    state_t state_reg, state_next;

    assign in_tready = (state_reg == S_IDLE);

    // command decode and next state
    always_comb
    begin
        cmd        = '0;
        cmd.kind   = KIND_IDLE;
        cmd.pid_src = PID_FROM_IN;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_tvalid)
                begin
                    cmd.ld_in  = 1'b1;
                    state_next = S_ADMIT;
                end
            end
            S_ADMIT:
            begin
                // latched item decides: admit, or start a slice (after a boost when one is due)
                if (sts.command == CMD_RUN)
                    state_next = sts.boost_due ? S_BFIND : S_PICK;
                else if (!sts.out_busy)
                begin
                    cmd.emit    = 1'b1;
                    cmd.last    = 1'b1;
                    cmd.pid_src = PID_FROM_IN;
                    if (sts.top_full)
                        cmd.kind = KIND_REJECTED;
                    else
                    begin
                        cmd.kind    = KIND_ADMITTED;
                        cmd.push_en = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_BFIND:
            begin
                if (sts.boost_hit && !sts.top_full)
                begin
                    cmd.pop_en  = 1'b1;
                    cmd.pop_lvl = sts.boost_lvl;
                    state_next  = S_BPUSH;
                end
                else
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_PICK;
                end
            end
            S_BPUSH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.push_en = 1'b1;
                    cmd.pid_src = PID_FROM_READ;
                    cmd.emit    = 1'b1;
                    cmd.kind    = KIND_BOOSTED;
                    state_next  = S_BFIND;
                end
            end
            S_PICK:
            begin
                if (sts.any_hit)
                begin
                    cmd.pop_en  = 1'b1;
                    cmd.pop_lvl = sts.head_lvl;
                    cmd.ld_cur  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_SLICE;
                end
                else if (!sts.out_busy)
                begin
                    cmd.emit    = 1'b1;
                    cmd.kind    = KIND_IDLE;
                    cmd.pid_src = PID_ZERO;
                    cmd.last    = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_SLICE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit    = 1'b1;
                    cmd.last    = 1'b1;
                    cmd.pid_src = PID_FROM_READ;
                    priority if (sts.outcome == OUT_EXIT || sts.outcome == OUT_EXIT_X)
                        cmd.kind = KIND_EXITED;
                    else if (sts.outcome == OUT_DEMOTE)
                    begin
                        cmd.kind     = KIND_DEMOTED;
                        cmd.push_en  = 1'b1;
                        cmd.push_lvl = sts.tgt_lvl;
                        cmd.emit_lvl = sts.tgt_lvl;
                    end
                    else
                    begin
                        cmd.kind     = KIND_STAYED;
                        cmd.push_en  = 1'b1;
                        cmd.push_lvl = sts.cur_lvl;
                        cmd.emit_lvl = sts.cur_lvl;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- rtl/mlfq_dpath.sv -----
// Level FIFOs, counters, configuration and result register.
module mlfq_dpath #(
    parameter int MAX_LEVELS = mlfq_pkg::DEF_MAX_LEVELS,
    parameter int MAX_PROCS  = mlfq_pkg::DEF_MAX_PROCS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mlfq_pkg::IN_W-1:0]     in_tdata,
    input  logic                          cfg_valid,
    input  logic                          cfg_index,
    input  logic [mlfq_pkg::CFG_W-1:0]    cfg_data,
    output logic                          out_tvalid,
    input  logic                          out_tready,
    output logic [mlfq_pkg::OUT_W-1:0]    out_tdata,
    output logic                          out_tlast,
    input  mlfq_pkg::mlfq_cmd_t           cmd,
    output mlfq_pkg::mlfq_sts_t           sts
);
    import mlfq_pkg::*;

    localparam int LW    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int PW    = $clog2(MAX_PROCS);
    localparam int CW    = $clog2(MAX_PROCS + 1);
    localparam int DEPTH = MAX_LEVELS * MAX_PROCS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [PID_W-1:0]    store [DEPTH];
    logic [PW-1:0]       head_reg  [MAX_LEVELS];
    logic [PW-1:0]       tail_reg  [MAX_LEVELS];
    logic [CW-1:0]       count_reg [MAX_LEVELS];
    logic [PERIOD_W-1:0] slice_reg;
    logic [LCNT_W-1:0]   lcount_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic                cmd_reg;
    logic [PID_W-1:0]    pid_reg;
    logic [1:0]          outcome_reg;
    logic [LW-1:0]       cur_reg;
    logic [PID_W-1:0]    rdata_reg;
    logic                ovalid_reg;
    logic [OUT_W-1:0]    odata_reg;
    logic                olast_reg;

    logic [LW-1:0]       pop_idx, push_idx, head_idx, boost_idx, tgt_idx;
    logic                any_hit, boost_hit;
    logic [PID_W-1:0]    push_pid, emit_pid;
    logic [LCNT_W:0]     levels;
    logic [LCNT_W:0]     cur_plus;

    assign pop_idx  = cmd.pop_lvl[LW-1:0];
    assign push_idx = cmd.push_lvl[LW-1:0];

    // highest non-empty level
    always_comb
    begin
        any_hit  = 1'b0;
        head_idx = '0;
        for (int i = MAX_LEVELS - 1; i >= 0; i--)
        begin
            if (count_reg[i] != '0)
            begin
                any_hit  = 1'b1;
                head_idx = LW'(i);
            end
        end
    end

    // highest non-empty level below the top, for boosting
    always_comb
    begin
        boost_hit = 1'b0;
        boost_idx = '0;
        for (int i = MAX_LEVELS - 1; i >= 1; i--)
        begin
            if (count_reg[i] != '0)
            begin
                boost_hit = 1'b1;
                boost_idx = LW'(i);
            end
        end
    end

    // demote target: next level if in use and not full
    always_comb
    begin
        levels = {1'b0, lcount_reg};
        if (lcount_reg == '0)
            levels = (LCNT_W+1)'(1);
        else if ({1'b0, lcount_reg} > (LCNT_W+1)'(MAX_LEVELS))
            levels = (LCNT_W+1)'(MAX_LEVELS);
        cur_plus = (LCNT_W+1)'(cur_reg) + 1'b1;
        tgt_idx  = cur_reg;
        if (cur_plus < levels && count_reg[cur_plus[LW-1:0]] != CW'(MAX_PROCS))
            tgt_idx = cur_plus[LW-1:0];
    end

    always_comb
    begin
        sts           = '0;
        sts.command   = command_t'(cmd_reg);
        sts.outcome   = outcome_t'(outcome_reg);
        sts.top_full  = (count_reg[0] == CW'(MAX_PROCS));
        sts.boost_due = (slice_reg == period_reg);
        sts.boost_hit = boost_hit;
        sts.boost_lvl = LVLS_W'(boost_idx);
        sts.any_hit   = any_hit;
        sts.head_lvl  = LVLS_W'(head_idx);
        sts.cur_lvl   = LVLS_W'(cur_reg);
        sts.tgt_lvl   = LVLS_W'(tgt_idx);
        sts.out_busy  = ovalid_reg;
    end

    always_comb
    begin
        unique case (cmd.pid_src)
            PID_FROM_IN:   push_pid = pid_reg;
            PID_FROM_READ: push_pid = rdata_reg;
            default:       push_pid = '0;
        endcase
        emit_pid = push_pid;
    end

    // FIFO storage: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.push_en)
            store[AW'(push_idx) * AW'(MAX_PROCS) + AW'(tail_reg[push_idx])] <= push_pid;
        if (cmd.pop_en)
            rdata_reg <= store[AW'(pop_idx) * AW'(MAX_PROCS) + AW'(head_reg[pop_idx])];
    end

    // head, tail and fill count per level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < MAX_LEVELS; i++)
            begin
                if (cmd.pop_en && pop_idx == LW'(i))
                begin
                    head_reg[i]  <= (head_reg[i] == PW'(MAX_PROCS - 1)) ? '0 : head_reg[i] + 1'b1;
                    count_reg[i] <= count_reg[i] - 1'b1;
                end
                if (cmd.push_en && push_idx == LW'(i))
                begin
                    tail_reg[i]  <= (tail_reg[i] == PW'(MAX_PROCS - 1)) ? '0 : tail_reg[i] + 1'b1;
                    count_reg[i] <= count_reg[i] + 1'b1;
                end
            end
        end
    end

    // configuration, slice counter and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcount_reg <= LEVEL_COUNT_RST;
            period_reg <= BOOST_PERIOD_RST;
            slice_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_LEVEL_COUNT:  lcount_reg <= cfg_data[LCNT_W-1:0];
                    CFG_BOOST_PERIOD: period_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.cnt_clr)
                slice_reg <= '0;
            else if (cmd.cnt_inc)
                slice_reg <= slice_reg + 1'b1;
            if (cmd.emit)
                ovalid_reg <= 1'b1;
            else if (out_tready)
                ovalid_reg <= 1'b0;
        end
    end

    // payload latches
    always_ff @(posedge clk)
    begin
        if (cmd.ld_in)
        begin
            cmd_reg     <= in_tdata[0];
            pid_reg     <= in_tdata[4:1];
            outcome_reg <= in_tdata[6:5];
        end
        if (cmd.ld_cur)
            cur_reg <= pop_idx;
        if (cmd.emit)
        begin
            odata_reg <= {6'd0, OUTLVL_W'(cmd.emit_lvl), emit_pid, cmd.kind};
            olast_reg <= cmd.last;
        end
    end

    assign out_tvalid = ovalid_reg;
    assign out_tdata  = odata_reg;
    assign out_tlast  = olast_reg;

endmodule

// ----- rtl/mlfq_checker.sv -----
// Port-level checks for the scheduler, bound to the top level.
module mlfq_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_tvalid,
    input logic                       in_tready,
    input logic                       out_tvalid,
    input logic                       out_tready,
    input logic [mlfq_pkg::OUT_W-1:0] out_tdata,
    input logic                       out_tlast
);
    import mlfq_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
        else $error("result changed while stalled");

    // boost results never close an item
    a_boost: assert property (@(posedge clk) disable iff (!rst_n)
        out_tvalid && out_tdata[2:0] == KIND_BOOSTED |-> !out_tlast)
        else $error("boost result marked last");

    // admit results are single, last and at the top level
    a_admit: assert property (@(posedge clk) disable iff (!rst_n)
        out_tvalid && (out_tdata[2:0] == KIND_ADMITTED || out_tdata[2:0] == KIND_REJECTED)
        |-> out_tlast && out_tdata[9:7] == 3'd0)
        else $error("bad admit result");

    // no new item while an earlier one still owes results
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_tvalid && !out_tlast |-> !in_tready)
        else $error("item accepted before results completed");

endmodule

bind mlfq_scheduler_with_boost mlfq_checker u_mlfq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
);

// ----- verif/mlfq_scheduler_with_boost_test.sv -----
// Self-checking testbench for the multilevel feedback queue scheduler with priority boost.
module mlfq_scheduler_with_boost_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mlfq_pkg::*;

    localparam int NLVL  = DEF_MAX_LEVELS;
    localparam int NPROC = DEF_MAX_PROCS;

    typedef struct packed {
        kind_t                kind;
        logic [PID_W-1:0]     pid;
        logic [OUTLVL_W-1:0]  lvl;
        logic                 last;
    } sched_result_t;

    // scoreboard: shadow scheduler state plus queue of predicted results
    class sched_scoreboard;
        logic [PID_W-1:0]    fifo_q [NLVL][$];
        logic [LCNT_W-1:0]   level_count;
        logic [PERIOD_W-1:0] boost_period;
        logic [PERIOD_W-1:0] slice_cnt;
        sched_result_t       pending_q [$];
        int                  mismatches;

        function void clear();
            foreach (fifo_q[i]) fifo_q[i].delete();
            level_count  = LEVEL_COUNT_RST;
            boost_period = BOOST_PERIOD_RST;
            slice_cnt    = '0;
            pending_q.delete();
            mismatches   = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
            if (idx == CFG_LEVEL_COUNT) level_count = val[LCNT_W-1:0];
            else boost_period = val[PERIOD_W-1:0];
        endfunction

        function void add(kind_t k, logic [PID_W-1:0] p, int l);
            sched_result_t r;
            r.kind = k;
            r.pid  = p;
            r.lvl  = OUTLVL_W'(l);
            r.last = 1'b0;
            pending_q = {pending_q, r};
        endfunction

        // predict results for one accepted item
        function void note_item(command_t cmd, logic [PID_W-1:0] pid, outcome_t oc);
            int levels, cur, tgt;
            logic [PID_W-1:0] p;
            levels = (level_count < 1) ? 1 : (level_count > NLVL ? NLVL : level_count);
            if (cmd == CMD_ADMIT) begin
                if (fifo_q[0].size() >= NPROC) add(KIND_REJECTED, pid, 0);
                else
                begin
                    fifo_q[0] = {fifo_q[0], pid};
                    add(KIND_ADMITTED, pid, 0);
                end
                pending_q[$].last = 1'b1;
                return;
            end
            // boost: lift lower levels into top while room remains
            if (slice_cnt == boost_period) begin
                for (int l = 1; l < NLVL; l++)
                    while (fifo_q[l].size() > 0 && fifo_q[0].size() < NPROC) begin
                        p = fifo_q[l].pop_front();
                        fifo_q[0] = {fifo_q[0], p};
                        add(KIND_BOOSTED, p, 0);
                    end
                slice_cnt = '0;
            end
            cur = NLVL;
            for (int l = NLVL - 1; l >= 0; l--)
                if (fifo_q[l].size() > 0) cur = l;
            if (cur == NLVL) add(KIND_IDLE, '0, 0);
            else
            begin
                p = fifo_q[cur].pop_front();
                slice_cnt = slice_cnt + 1'b1;
                if (oc == OUT_EXIT || oc == OUT_EXIT_X) add(KIND_EXITED, p, 0);
                else if (oc == OUT_DEMOTE) begin
                    tgt = cur;
                    if (cur + 1 < levels && fifo_q[cur + 1].size() < NPROC) tgt = cur + 1;
                    fifo_q[tgt] = {fifo_q[tgt], p};
                    add(KIND_DEMOTED, p, tgt);
                end
                else
                begin
                    fifo_q[cur] = {fifo_q[cur], p};
                    add(KIND_STAYED, p, cur);
                end
            end
            pending_q[$].last = 1'b1;
        endfunction

        function void check_result(sched_result_t got);
            sched_result_t exp_r;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind=%0d pid=%0d lvl=%0d last=%0b",
                             got.kind, got.pid, got.lvl, got.last);
                return;
            end
            exp_r = pending_q.pop_front();
            if (got !== exp_r) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result mismatch: exp kind=%0d pid=%0d lvl=%0d last=%0b,",
                              " got kind=%0d pid=%0d lvl=%0d last=%0b"},
                             exp_r.kind, exp_r.pid, exp_r.lvl, exp_r.last,
                             got.kind, got.pid, got.lvl, got.last);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_tvalid;
    logic                in_tready;
    logic [IN_W-1:0]     in_tdata;   // command, process_id, outcome
    logic                out_tvalid;
    logic                out_tready;
    logic [OUT_W-1:0]    out_tdata;  // kind, process_id_res, level
    logic                out_tlast;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    sched_scoreboard sb;
    bit              long_hold;

    mlfq_scheduler_with_boost dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

    // receiver: stall pattern, plus one long hold-off on request
    initial
    begin
        int hold;
        out_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold) begin
                out_tready <= 1'b0;
                for (hold = 0; hold < 300; hold++) @(negedge clk);
                long_hold = 1'b0;
            end
            case ($urandom_range(0, 3))
                0: out_tready <= ($urandom_range(0, 3) != 0);
                1: out_tready <= 1'b1;
                2: out_tready <= ($urandom_range(0, 1) == 0);
                default: out_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // output monitor
    always @(posedge clk)
        if (rst_n && out_tvalid && out_tready)
            sb.check_result({kind_t'(out_tdata[2:0]), out_tdata[6:3], out_tdata[9:7], out_tlast});

    task automatic send_item(command_t cmd, logic [PID_W-1:0] pid, outcome_t oc);
        in_tvalid <= 1'b1;
        in_tdata  <= {1'b0, oc, pid, cmd};
        @(posedge clk);
        while (!in_tready) @(posedge clk);
        sb.note_item(cmd, pid, oc);
        @(negedge clk);
    endtask

    task automatic idle_in();
        in_tvalid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        while (sb.pending_q.size() != 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random phase: bursts with gaps, share of admits set by admit_pct
    task automatic random_phase(int n, int admit_pct);
        int burst;
        int sent;
        sent = 0;
        while (sent < n) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < n; b++) begin
                send_item(($urandom_range(0, 99) < admit_pct) ? CMD_ADMIT : CMD_RUN,
                          PID_W'($urandom), outcome_t'($urandom_range(0, 3)));
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
                repeat ($urandom_range(1, 6)) idle_in();
        end
        idle_in();
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        rst_n      = 1'b0;
        in_tvalid  = 1'b0;
        in_tdata   = '0;
        cfg_valid  = 1'b0;
        cfg_index  = 1'b0;
        cfg_data   = '0;
        long_hold  = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: idle, all outcomes, extremes of pid
        send_item(CMD_RUN, 4'd0, OUT_YIELD);
        send_item(CMD_ADMIT, 4'd0, OUT_YIELD);
        send_item(CMD_ADMIT, 4'd15, OUT_EXIT_X);
        send_item(CMD_RUN, 4'd9, OUT_YIELD);
        send_item(CMD_RUN, 4'd0, OUT_DEMOTE);
        send_item(CMD_RUN, 4'd0, OUT_DEMOTE);
        send_item(CMD_RUN, 4'd0, OUT_DEMOTE);
        send_item(CMD_RUN, 4'd0, OUT_DEMOTE);
        send_item(CMD_RUN, 4'd0, OUT_EXIT_X);
        send_item(CMD_RUN, 4'd0, OUT_EXIT);
        idle_in();
        drain();

        // fill the top past capacity so admits get rejected, with a long receiver stall
        long_hold = 1'b1;
        for (int i = 0; i < 18; i++) send_item(CMD_ADMIT, PID_W'(i), OUT_YIELD);
        idle_in();
        drain();

        // small boost period, deepest levels: random mix starting from a full top
        write_reg(CFG_LEVEL_COUNT, 10'd8);
        write_reg(CFG_BOOST_PERIOD, 10'd1);
        random_phase(40, 20);
        drain();

        // single level, longest period
        write_reg(CFG_LEVEL_COUNT, 10'd1);
        write_reg(CFG_BOOST_PERIOD, 10'd1023);
        random_phase(30, 40);
        drain();

        // zero and out-of-range level counts, period lowered below counter
        write_reg(CFG_LEVEL_COUNT, 10'd0);
        write_reg(CFG_BOOST_PERIOD, 10'd3);
        random_phase(30, 40);
        drain();
        write_reg(CFG_LEVEL_COUNT, 10'd15);
        write_reg(CFG_BOOST_PERIOD, 10'd5);
        random_phase(50, 35);
        drain();
        write_reg(CFG_LEVEL_COUNT, 10'd3);
        write_reg(CFG_BOOST_PERIOD, 10'd1020);
        random_phase(40, 45);
        drain();

        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// ----- mlfq_scheduler_with_boost.f -----
rtl/mlfq_pkg.sv
rtl/mlfq_ctrl.sv
rtl/mlfq_dpath.sv
rtl/mlfq_scheduler_with_boost.sv
rtl/mlfq_checker.sv
verif/mlfq_scheduler_with_boost_test.sv
